/* sv/qse_pkg.sv */
// Package: sizes and types shared by the quicksort engine.
package qse_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int STACK_DEPTH  = 64;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int SP_W         = $clog2(STACK_DEPTH + 1);
    localparam int SADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W       = 32;
    localparam int RANGE_W      = 2 * IDX_W;

    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [SP_W-1:0]    sp_t;
    typedef logic [RANGE_W-1:0] range_t;

endpackage

/* sv/quicksort_engine.sv */
// Quicksort engine: element buffer, range stack and sequencer with one shared compare unit.
//
// Elements are loaded one per cycle while busy is low; an item with last high closes the batch
// and busy stays high until the last result has been shown. Items past the buffer depth of
// MAX_ELEMENTS are dropped and flag every result of that batch with overflow. The sort runs
// in place on a buffer with two read ports and one write port, so the single write port sets
// the pace of each partition, which also spends time on the pivot move, the final swap and
// the stack pushes and pop. Emission then reads each result from the buffer and shows it
// before it reads the next. Each result is presented for exactly one cycle with strobe high
// and cannot be held off by the receiver.
module quicksort_engine
    import qse_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last,
    output logic                     strobe,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     final_res,
    output logic                     overflow
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_LOAD,
        S_PSWAP1,
        S_PSWAP2,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SCAN_WR,
        S_FIN_RD,
        S_FIN_W1,
        S_FIN_W2,
        S_PUSH_LO,
        S_PUSH_HI,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    sp_t    sp_reg, sp_next;
    logic   dropped_reg, dropped_next;
    idx_t   lo_reg, lo_next;
    idx_t   hi_reg, hi_next;
    idx_t   i_reg, i_next;
    idx_t   dst_reg, dst_next;
    cnt_t   k_reg, k_next;
    data_t  pivot_reg, pivot_next;

    data_t  elem_mem [MAX_ELEMENTS];
    data_t  rd_a_reg, rd_b_reg;
    range_t stack_mem [STACK_DEPTH];
    range_t stk_rd_reg;

    logic   mem_we;
    idx_t   mem_wa;
    data_t  mem_wd;
    logic   rd_a_en, rd_b_en;
    idx_t   rd_a_addr, rd_b_addr;
    logic   stk_we;
    logic [SADDR_W-1:0] stk_wa;
    range_t stk_wd;
    logic   stk_re;
    logic [SADDR_W-1:0] stk_ra;

    logic [IDX_W:0] mid_sum;
    idx_t   mid;
    cnt_t   batch_cnt;
    sp_t    sp_dec;
    logic [IDX_W:0] lo_ext, hi_ext, dst_ext;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            elem_mem[mem_wa] <= mem_wd;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= elem_mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_reg <= elem_mem[rd_b_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_wa] <= stk_wd;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stack_mem[stk_ra];
        end
    end

    assign mid_sum   = {1'b0, stk_rd_reg[RANGE_W-1:IDX_W]} + {1'b0, stk_rd_reg[IDX_W-1:0]};
    assign mid       = mid_sum[IDX_W:1];
    assign batch_cnt = (count_reg < CNT_W'(MAX_ELEMENTS)) ? count_reg + 1'b1 : count_reg;
    assign sp_dec    = sp_reg - 1'b1;
    assign lo_ext    = {1'b0, lo_reg};
    assign hi_ext    = {1'b0, hi_reg};
    assign dst_ext   = {1'b0, dst_reg};

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        sp_next      = sp_reg;
        dropped_next = dropped_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        i_next       = i_reg;
        dst_next     = dst_reg;
        k_next       = k_reg;
        pivot_next   = pivot_reg;
        mem_we       = 1'b0;
        mem_wa       = dst_reg;
        mem_wd       = rd_a_reg;
        rd_a_en      = 1'b0;
        rd_b_en      = 1'b0;
        rd_a_addr    = i_reg;
        rd_b_addr    = dst_reg;
        stk_we       = 1'b0;
        stk_wa       = sp_reg[SADDR_W-1:0];
        stk_wd       = {lo_reg, hi_reg};
        stk_re       = 1'b0;
        stk_ra       = sp_dec[SADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (count_reg < CNT_W'(MAX_ELEMENTS))
                    begin
                        mem_we     = 1'b1;
                        mem_wa     = count_reg[IDX_W-1:0];
                        mem_wd     = data_t'(value);
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last)
                    begin
                        sp_next    = '0;
                        state_next = S_POP;
                        if (batch_cnt >= CNT_W'(2))
                        begin
                            stk_we  = 1'b1;
                            stk_wa  = '0;
                            stk_wd  = {idx_t'(0), idx_t'(batch_cnt - 1'b1)};
                            sp_next = SP_W'(1);
                        end
                    end
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    stk_re     = 1'b1;
                    sp_next    = sp_dec;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                lo_next = stk_rd_reg[RANGE_W-1:IDX_W];
                hi_next = stk_rd_reg[IDX_W-1:0];
                if (stk_rd_reg[RANGE_W-1:IDX_W] >= stk_rd_reg[IDX_W-1:0])
                begin
                    state_next = S_POP;
                end
                else
                begin
                    rd_a_en    = 1'b1;
                    rd_a_addr  = stk_rd_reg[IDX_W-1:0];
                    rd_b_en    = 1'b1;
                    rd_b_addr  = mid;
                    i_next     = mid;
                    state_next = S_PSWAP1;
                end
            end
            S_PSWAP1:
            begin
                mem_we     = 1'b1;
                mem_wa     = hi_reg;
                mem_wd     = rd_b_reg;
                pivot_next = rd_b_reg;
                state_next = S_PSWAP2;
            end
            S_PSWAP2:
            begin
                mem_we     = 1'b1;
                mem_wa     = i_reg;
                mem_wd     = rd_a_reg;
                i_next     = lo_reg;
                dst_next   = lo_reg;
                state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                if (i_reg == hi_reg)
                begin
                    state_next = S_FIN_RD;
                end
                else
                begin
                    rd_a_en    = 1'b1;
                    rd_b_en    = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if ($signed(rd_a_reg) <= $signed(pivot_reg))
                begin
                    mem_we     = 1'b1;
                    mem_wa     = dst_reg;
                    mem_wd     = rd_a_reg;
                    state_next = S_SCAN_WR;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_WR:
            begin
                mem_we     = 1'b1;
                mem_wa     = i_reg;
                mem_wd     = rd_b_reg;
                i_next     = i_reg + 1'b1;
                dst_next   = dst_reg + 1'b1;
                state_next = S_SCAN_RD;
            end
            S_FIN_RD:
            begin
                rd_b_en    = 1'b1;
                state_next = S_FIN_W1;
            end
            S_FIN_W1:
            begin
                mem_we     = 1'b1;
                mem_wa     = hi_reg;
                mem_wd     = rd_b_reg;
                state_next = S_FIN_W2;
            end
            S_FIN_W2:
            begin
                mem_we     = 1'b1;
                mem_wa     = dst_reg;
                mem_wd     = pivot_reg;
                state_next = S_PUSH_LO;
            end
            S_PUSH_LO:
            begin
                if (dst_ext > lo_ext + 1'b1 && sp_reg < SP_W'(STACK_DEPTH))
                begin
                    stk_we  = 1'b1;
                    stk_wd  = {lo_reg, dst_reg - 1'b1};
                    sp_next = sp_reg + 1'b1;
                end
                state_next = S_PUSH_HI;
            end
            S_PUSH_HI:
            begin
                if (dst_ext + 1'b1 < hi_ext && sp_reg < SP_W'(STACK_DEPTH))
                begin
                    stk_we  = 1'b1;
                    stk_wd  = {dst_reg + 1'b1, hi_reg};
                    sp_next = sp_reg + 1'b1;
                end
                state_next = S_POP;
            end
            S_EMIT_RD:
            begin
                if (k_reg == count_reg)
                begin
                    count_next   = '0;
                    sp_next      = '0;
                    dropped_next = 1'b0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    rd_a_en    = 1'b1;
                    rd_a_addr  = k_reg[IDX_W-1:0];
                    k_next     = k_reg + 1'b1;
                    state_next = S_EMIT_OUT;
                end
            end
            S_EMIT_OUT:
            begin
                state_next = S_EMIT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            sp_reg      <= '0;
            dropped_reg <= 1'b0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sp_reg      <= sp_next;
            dropped_reg <= dropped_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        dst_reg   <= dst_next;
        pivot_reg <= pivot_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign strobe       = (state_reg == S_EMIT_OUT);
    assign sorted_value = $signed(rd_a_reg);
    assign final_res    = (k_reg == count_reg);
    assign overflow     = dropped_reg;

endmodule
